/* rtl/slm_pkg.sv */
// Shared constants and register codes for the stereo RMS level meter.
`default_nettype none

package slm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_FRAMES_DEF = 256;

    localparam int KEEP_W  = 16;
    localparam int LEVEL_W = 15;
    localparam int SCALE_W = 16;
    localparam int BLOCK_W = 32;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_KEEP = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE  = CFG_INDEX_W'(1);

    localparam logic [KEEP_W-1:0]  KEEP_RESET = KEEP_W'(60948);
    localparam logic [LEVEL_W-1:0] FS_RESET   = LEVEL_W'(5571);

    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

endpackage

`default_nettype wire

/* rtl/stereo_rms_level_meter.sv */
// Stereo RMS level meter: two squaring lanes, block accumulator, mean/root/smooth/scale.
// A frame that does not close a block goes through the lane square register, then the accumulate state.
// A closing frame runs the shared divider twice and the root unit once; no frame is taken
// meanwhile.
// A finished result waits in the output register while the next frames are taken.
// Synchronous active-low reset clears sums, counts, smoothed level, block count, out valid.
`default_nettype none

module stereo_rms_level_meter #(
    parameter int MAX_FRAMES = slm_pkg::MAX_FRAMES_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_wr_en,
    input  wire  [slm_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire  [slm_pkg::CFG_DATA_W-1:0]        i_cfg_wr_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  signed [slm_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  wire  signed [slm_pkg::SAMPLE_BITS-1:0] i_right_sample,
    input  wire                                   i_last_frame,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [slm_pkg::LEVEL_W-1:0]           o_rms_level,
    output logic [slm_pkg::LEVEL_W-1:0]           o_smoothed_level,
    output logic [slm_pkg::SCALE_W-1:0]           o_scaled_level,
    output logic [slm_pkg::BLOCK_W-1:0]           o_blocks_seen
);
    import slm_pkg::*;

    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int CW     = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = SQ_W + CW;
    localparam int QW     = SUM_W - 3;
    localparam int QW2    = QW + (QW % 2);
    localparam int RW     = QW2 / 2;
    localparam int RMS_W  = (RW > LEVEL_W) ? RW : LEVEL_W + 1;
    localparam int SCL_DD = LEVEL_W + 16;
    localparam int DIV_W  = (QW > SCL_DD) ? QW : SCL_DD;
    localparam int DVS_W  = (CW > LEVEL_W) ? CW : LEVEL_W;
    localparam logic [CW-1:0] FRAME_LIMIT = CW'(MAX_FRAMES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_MEAN  = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]         r_state;
    logic [KEEP_W-1:0]  r_keep;
    logic [LEVEL_W-1:0] r_fs;
    logic [SUM_W-1:0]   r_sum;
    logic [CW-1:0]      r_count;
    logic               r_last;
    logic [LEVEL_W-1:0] r_smoothed;
    logic [BLOCK_W-1:0] r_blocks;
    logic [LEVEL_W-1:0] r_rms;
    logic [30:0]        r_prod_old;
    logic [31:0]        r_prod_new;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_rms;
    logic [LEVEL_W-1:0] r_out_sm;
    logic [SCALE_W-1:0] r_out_scaled;
    logic [BLOCK_W-1:0] r_out_blocks;

    logic               accept;
    logic [SQ_W-1:0]    sq_left;
    logic [SQ_W-1:0]    sq_right;
    logic [SUM_W-1:0]   n_sum;
    logic [CW-1:0]      n_count;
    logic               block_end;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;

    t_unit_ctl          root_ctl;
    logic               root_done;
    logic [RW-1:0]      root;
    logic [RMS_W-1:0]   root_ext;
    logic [LEVEL_W-1:0] rms_clip;

    logic [32:0]        sm_sum;
    logic [16:0]        sm_raw;
    logic [LEVEL_W-1:0] n_smoothed;
    logic [LEVEL_W-1:0] fs_eff;
    logic [SCALE_W-1:0] scaled;
    logic               out_free;
    logic               out_load;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    slm_lane u_lane_left (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_sample (i_left_sample),
        .o_square (sq_left)
    );

    slm_lane u_lane_right (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_sample (i_right_sample),
        .o_square (sq_right)
    );

    // merge the lanes into the block sum
    assign n_sum     = r_sum + SUM_W'(sq_left) + SUM_W'(sq_right);
    assign n_count   = r_count + CW'(1);
    assign block_end = r_last || (n_count == FRAME_LIMIT);

    assign root_ext = RMS_W'(root);
    assign rms_clip = (|root_ext[RMS_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : root_ext[LEVEL_W-1:0];

    assign sm_sum     = 33'(r_prod_old) + 33'(r_prod_new) + 33'd32768;
    assign sm_raw     = sm_sum[32:16];
    assign n_smoothed = (|sm_raw[16:LEVEL_W]) ? {LEVEL_W{1'b1}} : sm_raw[LEVEL_W-1:0];
    assign fs_eff     = (r_fs == '0) ? LEVEL_W'(1) : r_fs;
    assign scaled     = (|div_quo[DIV_W-1:SCALE_W]) ? {SCALE_W{1'b1}} : div_quo[SCALE_W-1:0];

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            S_ACC: begin
                div_start    = block_end;
                div_dividend = DIV_W'(n_sum >> 3);
                div_divisor  = DVS_W'(n_count);
            end
            S_SUM: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({n_smoothed, 16'h0000});
                div_divisor  = DVS_W'(fs_eff);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    slm_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign root_ctl.start = (r_state == S_MEAN) && div_done;
    assign root_ctl.done  = 1'b0;

    slm_sqrt #(
        .OPERAND_W (QW2)
    ) u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (root_ctl),
        .i_operand (QW2'(div_quo[QW-1:0])),
        .o_done    (root_done),
        .o_root    (root)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_RESET;
            r_fs   <= FS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SMOOTH_KEEP: r_keep <= i_cfg_wr_data[KEEP_W-1:0];
                REG_FULL_SCALE:  r_fs   <= i_cfg_wr_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sum      <= '0;
            r_count    <= '0;
            r_last     <= 1'b0;
            r_smoothed <= '0;
            r_blocks   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last  <= i_last_frame;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (block_end) begin
                        r_sum   <= '0;
                        r_count <= '0;
                        r_state <= S_MEAN;
                    end else begin
                        r_sum   <= n_sum;
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (root_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_smoothed <= n_smoothed;
                    r_state    <= S_SCALE;
                end
                S_SCALE: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_blocks <= r_blocks + BLOCK_W'(1);
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROOT && root_done) begin
            r_rms <= rms_clip;
        end
        if (r_state == S_MUL) begin
            r_prod_old <= r_keep * r_smoothed;
            r_prod_new <= (17'h10000 - 17'(r_keep)) * r_rms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rms    <= r_rms;
            r_out_sm     <= r_smoothed;
            r_out_scaled <= scaled;
            r_out_blocks <= r_blocks + BLOCK_W'(1);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_rms_level      = r_out_rms;
    assign o_smoothed_level = r_out_sm;
    assign o_scaled_level   = r_out_scaled;
    assign o_blocks_seen    = r_out_blocks;

endmodule

`default_nettype wire

/* rtl/slm_lane.sv */
// One channel lane: magnitude and square of a sample, registered.
`default_nettype none

module slm_lane (
    input  wire                               i_clk,
    input  wire                               i_load,
    input  wire  signed [slm_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic [2*slm_pkg::SAMPLE_BITS-2:0] o_square
);
    import slm_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_BITS - 1;

    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] prod;
    logic [SQ_W-1:0]          r_square;

    // -32768 maps to 32768 as an unsigned magnitude
    assign mag  = i_sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - i_sample) : i_sample;
    assign prod = mag * mag;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_square <= prod[SQ_W-1:0];
        end
    end

    assign o_square = r_square;

endmodule

`default_nettype wire

/* rtl/slm_div.sv */
// Restoring divider, one quotient bit per clock.
`default_nettype none

module slm_div #(
    parameter int DIVIDEND_W = 37,
    parameter int DIVISOR_W  = 15
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [DIVIDEND_W-1:0] i_dividend,
    input  wire  [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DIVISOR_W'(trial - {1'b0, r_dvs}) : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/slm_sqrt.sv */
// Integer square root, one root bit per clock.
`default_nettype none

module slm_sqrt #(
    parameter int OPERAND_W = 38
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire  slm_pkg::t_unit_ctl i_ctl,
    input  wire  [OPERAND_W-1:0]     i_operand,
    output logic                     o_done,
    output logic [OPERAND_W/2-1:0]   o_root
);
    import slm_pkg::*;

    localparam int ROOT_W = OPERAND_W / 2;
    localparam int CNT_W  = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [OPERAND_W-1:0] r_op;
    logic [ROOT_W:0]      r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [ROOT_W+2:0]    rem_sh;
    logic [ROOT_W+2:0]    trial;
    logic                 fits;

    assign rem_sh = {r_rem, r_op[OPERAND_W-1 -: 2]};
    assign trial  = (ROOT_W+3)'({r_root, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op   <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op   <= {r_op[OPERAND_W-3:0], 2'b00};
            r_rem  <= fits ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for stereo_rms_level_meter: directed frame table, then predictor-checked random blocks.
module testbench;
    import slm_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_FRAMES = 110;
    localparam int NUM_PHASES   = 8;
    localparam int REPORT_MAX   = 10;
    localparam int NUM_ROWS     = 18;
    localparam int EXP_DEPTH    = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_TOP    = '1;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] smoothed;
        logic [SCALE_W-1:0] scaled;
        logic [BLOCK_W-1:0] blocks;
    } t_level_report;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          last;
        logic                          typed;
        t_level_report                 want;
    } t_frame_row;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0]        i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_wr_data  = '0;
    logic                          i_in_valid     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_left_sample  = '0;
    logic signed [SAMPLE_BITS-1:0] i_right_sample = '0;
    logic                          i_last_frame   = 1'b0;
    logic                          i_out_stall    = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [LEVEL_W-1:0]            o_rms_level;
    logic [LEVEL_W-1:0]            o_smoothed_level;
    logic [SCALE_W-1:0]            o_scaled_level;
    logic [BLOCK_W-1:0]            o_blocks_seen;

    // predictor state and register copies
    logic [39:0]        acc_energy   = '0;
    logic [8:0]         acc_frames   = '0;
    logic [LEVEL_W-1:0] smooth_now   = '0;
    logic [BLOCK_W-1:0] block_total  = '0;
    logic [KEEP_W-1:0]  keep_weight  = KEEP_RESET;
    logic [LEVEL_W-1:0] full_scale   = FS_RESET;

    t_level_report expect_fifo [EXP_DEPTH];
    int            exp_wr         = 0;
    int            exp_rd         = 0;
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    t_frame_row directed_rows [NUM_ROWS] = '{
        '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{15'd0, 15'd0, 16'd0, 32'd1}},
        '{16'sh8000, 16'sh8000, 1'b1, 1'b1, '{15'd16384, 15'd1147, 16'd13493, 32'd2}},
        '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, '0},
        '{16'sh7FFF, 16'sh8000, 1'b1, 1'b0, '0},
        '{16'shFFFF, 16'sh0001, 1'b1, 1'b0, '0},
        '{16'sh0000, 16'sh8000, 1'b0, 1'b0, '0},
        '{16'sh5555, 16'shAAAA, 1'b0, 1'b0, '0},
        '{16'shAAAA, 16'sh5555, 1'b1, 1'b0, '0},
        '{16'sh0064, 16'shFF9C, 1'b0, 1'b0, '0},
        '{16'sh03E8, 16'sh07D0, 1'b0, 1'b0, '0},
        '{16'shF448, 16'sh0FA0, 1'b0, 1'b0, '0},
        '{16'sh7FFF, 16'sh0000, 1'b1, 1'b0, '0},
        '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, '0},
        '{16'sh0000, 16'sh0000, 1'b1, 1'b0, '0},
        '{16'sh3039, 16'shCFC7, 1'b1, 1'b0, '0},
        '{16'shC000, 16'sh4000, 1'b1, 1'b0, '0},
        '{16'sh2000, 16'shE000, 1'b1, 1'b0, '0},
        '{16'sh0001, 16'shFFFF, 1'b1, 1'b0, '0}
    };

    stereo_rms_level_meter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_last_frame     (i_last_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_rms_level      (o_rms_level),
        .o_smoothed_level (o_smoothed_level),
        .o_scaled_level   (o_scaled_level),
        .o_blocks_seen    (o_blocks_seen)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Accumulate one frame; on block close, produce rms, smoothed and scaled levels and block count.
    task automatic meter_predict(input logic signed [SAMPLE_BITS-1:0] l,
                                 input logic signed [SAMPLE_BITS-1:0] r,
                                 input logic last, output logic closed,
                                 output t_level_report rep);
        longint          sl;
        longint          sr;
        longint unsigned mean_sq;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned blend;
        longint unsigned ratio;
        longint unsigned fs;
        sl = l;
        sr = r;
        acc_energy = acc_energy + 40'(sl * sl + sr * sr);
        acc_frames = acc_frames + 9'd1;
        closed = last || (acc_frames >= MAX_FRAMES_DEF);
        rep = '0;
        if (closed) begin
            mean_sq = 64'(acc_energy) / (64'(acc_frames) * 64'd8);
            root = 0;
            for (int b = 15; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= mean_sq)
                    root = trial;
            end
            if (root > 64'h7FFF)
                root = 64'h7FFF;
            blend = (64'(keep_weight) * 64'(smooth_now)
                     + (64'd65536 - 64'(keep_weight)) * root + 64'd32768) >> 16;
            if (blend > 64'h7FFF)
                blend = 64'h7FFF;
            smooth_now = LEVEL_W'(blend);
            fs = (full_scale == '0) ? 64'd1 : 64'(full_scale);
            ratio = (blend << 16) / fs;
            if (ratio > 64'hFFFF)
                ratio = 64'hFFFF;
            block_total = block_total + 1'b1;
            acc_energy = '0;
            acc_frames = '0;
            rep = '{LEVEL_W'(root), LEVEL_W'(blend), SCALE_W'(ratio), block_total};
        end
    endtask

    task automatic send_frame(input t_frame_row row);
        logic          closed;
        t_level_report rep;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_left_sample  <= row.left;
        i_right_sample <= row.right;
        i_last_frame   <= row.last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        meter_predict(row.left, row.right, row.last, closed, rep);
        if (closed) begin
            expect_fifo[exp_wr % EXP_DEPTH] = row.typed ? row.want : rep;
            exp_wr++;
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int style);
        logic signed [SAMPLE_BITS-1:0] s;
        s = SAMPLE_BITS'($urandom);
        if (style < 15) begin
            s = SAMPLE_BITS'($urandom_range(0, 255)) - 16'sd128;
        end else if (style < 35) begin
            case ($urandom_range(0, 4))
                0: s = 16'sh8000;
                1: s = 16'sh7FFF;
                2: s = 16'shFFFF;
                3: s = 16'sh0000;
                default: s = 16'sh0001;
            endcase
        end else if (style < 40) begin
            s = '0;
        end
        return s;
    endfunction

    // long_len > 0 opens the phase with a block of that length; unmarked ones close on count
    task automatic run_blocks(input int budget, input int long_len, input logic long_marked);
        t_frame_row row;
        int         sent;
        int         len;
        int         style;
        logic       marked;
        sent = 0;
        while (sent < budget) begin
            marked = 1'b1;
            if (sent == 0 && long_len > 0) begin
                len = long_len;
                marked = long_marked;
            end else if ($urandom_range(0, 99) < 15) begin
                len = $urandom_range(9, 60);
            end else begin
                len = $urandom_range(1, 8);
            end
            style = $urandom_range(0, 99);
            for (int k = 1; k <= len; k++) begin
                row = '0;
                row.left  = pick_sample(style);
                row.right = pick_sample(style);
                row.last  = (k == len) && marked;
                send_frame(row);
                sent++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_SMOOTH_KEEP)
            keep_weight = data;
        else if (idx == REG_FULL_SCALE)
            full_scale = data[LEVEL_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic settle_meter();
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input t_level_report want,
                                 input t_level_report got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     what, want.rms, want.smoothed, want.scaled, want.blocks,
                     got.rms, got.smoothed, got.scaled, got.blocks);
    endtask

    always @(posedge i_clk) begin : level_rx
        t_level_report got;
        t_level_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_rms_level, o_smoothed_level, o_scaled_level, o_blocks_seen};
            if (exp_wr == exp_rd) begin
                flag_mismatch("unexpected transaction", '0, got);
            end else begin
                want = expect_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got !== want)
                    flag_mismatch("level mismatch", want, got);
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_ROWS; n++)
            send_frame(directed_rows[n]);
        i_in_valid <= 1'b0;

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            settle_meter();
            case (ph)
                1: begin
                    write_reg(REG_SMOOTH_KEEP, 16'h0000);
                    write_reg(REG_FULL_SCALE, 16'h0001);
                end
                2: begin
                    write_reg(REG_SMOOTH_KEEP, 16'hFFFF);
                    write_reg(REG_FULL_SCALE, 16'hFFFF);
                end
                3: begin
                    write_reg(REG_SMOOTH_KEEP, 16'h8000);
                    write_reg(REG_FULL_SCALE, 16'h0000);
                end
                4: begin
                    write_reg(REG_SMOOTH_KEEP, KEEP_RESET);
                    write_reg(REG_FULL_SCALE, 16'h7FFF);
                    write_reg(REG_UNUSED, 16'h0003);
                    write_reg(REG_TOP, 16'h0001);
                end
                6: begin
                    write_reg(REG_SMOOTH_KEEP, 16'h0001);
                    write_reg(REG_FULL_SCALE, CFG_DATA_W'(FS_RESET));
                end
                default: begin
                    write_reg(REG_SMOOTH_KEEP, CFG_DATA_W'($urandom));
                    write_reg(REG_FULL_SCALE, CFG_DATA_W'($urandom_range(1, 32767)));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (ph == 3)
                run_blocks(PHASE_FRAMES, MAX_FRAMES_DEF, 1'b0);
            else if (ph == 6)
                run_blocks(PHASE_FRAMES, MAX_FRAMES_DEF + 14, 1'b1);
            else
                run_blocks(PHASE_FRAMES, 0, 1'b1);
            i_in_valid <= 1'b0;
        end

        settle_meter();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* stereo_rms_level_meter.f */
rtl/slm_pkg.sv
rtl/slm_lane.sv
rtl/slm_div.sv
rtl/slm_sqrt.sv
rtl/stereo_rms_level_meter.sv
tb/testbench.sv
